// ===== hw/rtl/fgp_pkg.sv =====
// Shared types, constants and gain tables for the fuzzy gain PID speed loop.
package fgp_pkg;

  // Width of a scheduled gain (base gain times 16 plus a table offset).
  localparam int GAIN_W = 22;
  localparam int ROM_N  = 49;

  // Fixed-point constants, all in 1/65536 units.
  localparam int K_SMOOTH_OLD = 45875;
  localparam int K_SMOOTH_NEW = 19661;
  localparam int K_LEAK       = 62259;
  localparam int I_STEP_LIM   = 9830;
  localparam int ERR_HI       = 229376;
  localparam int ERR_LO       = -294912;
  localparam int RISE_LIM     = 6554;
  localparam int FALL_LIM     = 65536;

  // Table entries are in 1/10000 units, scaled down by 10, 50 and 20.
  localparam longint DEN_P = 100000;
  localparam longint DEN_I = 500000;
  localparam longint DEN_D = 200000;

  // Upper bin edges (inclusive) for the error and the error trend.
  localparam int E_EDGES  [6] = '{-65536, -32768, -13107, 13107, 32768, 65536};
  localparam int EC_EDGES [6] = '{-19661, -13107, -6554, 6554, 13107, 19661};

  // Configuration register indexes.
  localparam logic [2:0] CFG_BASE_P  = 3'd0;
  localparam logic [2:0] CFG_BASE_I  = 3'd1;
  localparam logic [2:0] CFG_BASE_D  = 3'd2;
  localparam logic [2:0] CFG_FLOOR   = 3'd3;
  localparam logic [2:0] CFG_CEILING = 3'd4;

  typedef int raw_t [ROM_N];
  typedef logic signed [15:0] rom_t [ROM_N];

  // Raw rule tables, row = error bin, column = trend bin.
  localparam raw_t RAW_P = '{
    24300, 19400, 17700, 12500, 6900, 4000, 60,
    19400, 19400, 13500, 6900, 2600, 30, -6000,
    17700, 13500, 9090, 6900, -50, -2600, -10900,
    12500, 8000, 2600, 1000, -1000, -6900, -12500,
    10900, 2600, -40, -2600, -6900, -9090, -17700,
    5960, -1000, -2600, -8000, -13500, -13600, -19400,
    -60, -5000, -8000, -16700, -17700, -19400, -24300};
  localparam raw_t RAW_I = '{
    -24300, -19400, -17700, -12500, -6900, -4000, -60,
    -24300, -14800, -13500, -6900, -2600, -30, 4000,
    -19400, -9090, -8000, -2600, 1000, 2600, 6900,
    -17700, -8000, -1000, 30, 2600, 9090, 13500,
    -8000, -2600, 50, 6900, 8000, 13500, 19400,
    -5000, -1000, 2600, 6930, 13500, 14800, 24300,
    60, 4000, 6900, 12500, 17700, 19400, 24300};
  localparam raw_t RAW_D = '{
    10000, -3710, -14800, -24300, -19400, -4440, 9700,
    6000, -3710, -14800, -13500, -13500, -3810, 4000,
    4000, -3710, -13500, -9090, -6900, -6900, -120,
    -120, -6900, -6900, -6900, -5000, -6000, -119,
    5620, 2180, 0, 0, 0, 2180, 5620,
    9720, 715, 2620, 6930, 6900, 8000, 9720,
    24300, 17700, 16700, 12500, 10900, 12000, 24300};

  // Scale the raw tables to Q16, rounding half away from zero.
  function automatic rom_t scale_p();
    rom_t   r;
    longint mag;
    longint q;
    for (int i = 0; i < ROM_N; i++) begin
      mag  = (RAW_P[i] < 0) ? -longint'(RAW_P[i]) : longint'(RAW_P[i]);
      q    = (mag * 65536 + DEN_P / 2) / DEN_P;
      r[i] = 16'((RAW_P[i] < 0) ? -q : q);
    end
    return r;
  endfunction

  function automatic rom_t scale_i();
    rom_t   r;
    longint mag;
    longint q;
    for (int i = 0; i < ROM_N; i++) begin
      mag  = (RAW_I[i] < 0) ? -longint'(RAW_I[i]) : longint'(RAW_I[i]);
      q    = (mag * 65536 + DEN_I / 2) / DEN_I;
      r[i] = 16'((RAW_I[i] < 0) ? -q : q);
    end
    return r;
  endfunction

  function automatic rom_t scale_d();
    rom_t   r;
    longint mag;
    longint q;
    for (int i = 0; i < ROM_N; i++) begin
      mag  = (RAW_D[i] < 0) ? -longint'(RAW_D[i]) : longint'(RAW_D[i]);
      q    = (mag * 65536 + DEN_D / 2) / DEN_D;
      r[i] = 16'((RAW_D[i] < 0) ? -q : q);
    end
    return r;
  endfunction

  localparam rom_t ROM_P = scale_p();
  localparam rom_t ROM_I = scale_i();
  localparam rom_t ROM_D = scale_d();

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_MUL_T, ST_MUL_E, ST_SMOOTH, ST_TREND, ST_LEAK, ST_INTEG,
    ST_MUL_P, ST_MUL_I, ST_MUL_D, ST_SLEW, ST_CLAMP, ST_DONE
  } state_t;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic en;
    logic clr;
  } mac_ctl_t;

  // Scheduled gains for one sample.
  typedef struct packed {
    logic signed [GAIN_W-1:0] gp;
    logic signed [GAIN_W-1:0] gi;
    logic signed [GAIN_W-1:0] gd;
  } gains_t;

endpackage

// ===== hw/rtl/fgp_mac.sv =====
// Shared signed multiply-accumulate unit used by every product of the loop.
module fgp_mac import fgp_pkg::*; #(
  parameter int W = 24
) (
  input  logic                    clk,
  input  mac_ctl_t                ctl,
  input  logic signed [GAIN_W-1:0] a,
  input  logic signed [W:0]       b,
  output logic signed [W+25:0]    acc
);

  localparam int AW = W + 26;

  logic signed [GAIN_W+W:0] prod;

  assign prod = a * b;

  // Either start a new sum or add to the running one.
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc <= (ctl.clr ? AW'(0) : acc) + AW'(prod);
    end
  end

endmodule

// ===== hw/rtl/fgp_gain_lut.sv =====
// Bin selection for error and trend, rule table lookup and gain scheduling.
module fgp_gain_lut import fgp_pkg::*; #(
  parameter int W = 24
) (
  input  logic signed [W-1:0] smoothed,
  input  logic signed [W-1:0] trend,
  input  logic signed [15:0]  base_p,
  input  logic signed [15:0]  base_i,
  input  logic signed [15:0]  base_d,
  output gains_t              gains
);

  logic [2:0] be;
  logic [2:0] bc;
  logic [5:0] idx;

  // The lowest bin whose upper edge is not below the value wins.
  always_comb begin
    be = 3'd6;
    bc = 3'd6;
    for (int i = 5; i >= 0; i--) begin
      if (int'(smoothed) <= E_EDGES[i]) be = 3'(i);
      if (int'(trend) <= EC_EDGES[i]) bc = 3'(i);
    end
  end

  assign idx = {3'b000, be} * 6'd7 + {3'b000, bc};

  // Base gains arrive in 1/4096 units and are moved to Q16.
  assign gains.gp = GAIN_W'($signed({base_p, 4'b0000})) + GAIN_W'(ROM_P[idx]);
  assign gains.gi = GAIN_W'($signed({base_i, 4'b0000})) + GAIN_W'(ROM_I[idx]);
  assign gains.gd = GAIN_W'($signed({base_d, 4'b0000})) + GAIN_W'(ROM_D[idx]);

endmodule

// ===== hw/rtl/fuzzy_gain_pid_speed_to_accel_core.sv =====
// Top level: sequencer, loop state and stream ports of the fuzzy gain PID block.
// An input transfer runs ST_PREP to ST_DONE in order, one state per cycle, but ST_DONE
// holds until the output is free. Every product passes one shared multiplier in turn
// (six multiply-accumulate steps and their rounding steps).
// A new sample is taken only in ST_IDLE, even while a result still waits on the output.
// Synchronous reset clears the loop state and handshakes and restores the configuration.
module fuzzy_gain_pid_speed_to_accel_core import fgp_pkg::*; #(
  parameter int INTERNAL_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // desired_speed[15:0], measured_speed[31:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // accel_command[12:0], zero[15:13]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int W  = INTERNAL_WIDTH;
  localparam int AW = W + 26;
  localparam logic signed [AW-1:0] SAT_HI = AW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);
  localparam logic signed [AW-1:0] HALF16 = AW'(32768);

  function automatic logic signed [W-1:0] sat_w(input logic signed [AW-1:0] x);
    logic signed [W-1:0] r;
    if (x > SAT_HI) r = W'(SAT_HI);
    else if (x < SAT_LO) r = W'(SAT_LO);
    else r = W'(x);
    return r;
  endfunction

  state_t state;
  state_t state_next;

  // Configuration registers.
  logic signed [15:0] base_p_gain;
  logic signed [15:0] base_i_gain;
  logic signed [15:0] base_d_gain;
  logic signed [12:0] accel_floor;
  logic        [11:0] accel_ceiling;

  // Loop state and working registers.
  logic signed [W-1:0]  smoothed_error;
  logic signed [W-1:0]  error_history [4];
  logic signed [W-1:0]  error_trend;
  logic signed [W-1:0]  leaky_integral;
  logic signed [W-1:0]  previous_accel;
  logic signed [15:0]   desired;
  logic signed [15:0]   measured;
  logic signed [W-1:0]  e_reg;
  logic signed [W-1:0]  t_reg;
  logic signed [AW-1:0] accel_tmp;
  gains_t               gains;
  logic [12:0]          accel_command;

  // Shared unit connections.
  mac_ctl_t                 mac_ctl;
  logic signed [GAIN_W-1:0] mac_a;
  logic signed [W:0]        mac_b;
  logic signed [AW-1:0]     acc;
  gains_t                   gains_lut;

  // Combinational helpers.
  logic signed [16:0]   speed_diff;
  logic signed [W-1:0]  err_clamp;
  logic signed [W-1:0]  i_step;
  logic signed [AW-1:0] acc_round;
  logic signed [AW-1:0] prev_ext;
  logic signed [AW-1:0] slew_diff;
  logic signed [AW-1:0] accel_hi;
  logic signed [AW-1:0] accel_lo;
  logic signed [W:0]    out_round;
  logic                 out_free;

  fgp_mac #(.W(W)) u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  fgp_gain_lut #(.W(W)) u_lut (
    .smoothed (smoothed_error),
    .trend    (error_trend),
    .base_p   (base_p_gain),
    .base_i   (base_i_gain),
    .base_d   (base_d_gain),
    .gains    (gains_lut)
  );

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {3'b000, accel_command};
  assign out_free = !m_tvalid || m_tready;

  assign speed_diff = 17'(desired) - 17'(measured);
  assign acc_round  = (acc + HALF16) >>> 16;
  assign prev_ext   = AW'(previous_accel);
  assign slew_diff  = acc_round - prev_ext;
  assign accel_hi   = AW'($signed({1'b0, accel_ceiling, 8'h00}));
  assign accel_lo   = AW'($signed({accel_floor, 8'h00}));
  assign out_round  = ((W+1)'(previous_accel) + (W+1)'(128)) >>> 8;

  // Clamps on the new smoothed error for the PID term and the integral step.
  always_comb begin
    if (int'(smoothed_error) > ERR_HI) err_clamp = W'(ERR_HI);
    else if (int'(smoothed_error) < ERR_LO) err_clamp = W'(ERR_LO);
    else err_clamp = smoothed_error;
    if (int'(smoothed_error) > I_STEP_LIM) i_step = W'(I_STEP_LIM);
    else if (int'(smoothed_error) < -I_STEP_LIM) i_step = W'(-I_STEP_LIM);
    else i_step = smoothed_error;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and operand selection for the shared unit.
  always_comb begin
    state_next = state;
    mac_ctl    = '0;
    mac_a      = '0;
    mac_b      = '0;
    unique case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_PREP;
      ST_PREP:   state_next = ST_MUL_T;
      ST_MUL_T: begin
        mac_ctl    = '{en: 1'b1, clr: 1'b1};
        mac_a      = GAIN_W'(K_SMOOTH_OLD);
        mac_b      = (W+1)'(t_reg);
        state_next = ST_MUL_E;
      end
      ST_MUL_E: begin
        mac_ctl    = '{en: 1'b1, clr: 1'b0};
        mac_a      = GAIN_W'(K_SMOOTH_NEW);
        mac_b      = (W+1)'(e_reg);
        state_next = ST_SMOOTH;
      end
      ST_SMOOTH: state_next = ST_TREND;
      ST_TREND:  state_next = ST_LEAK;
      ST_LEAK: begin
        mac_ctl    = '{en: 1'b1, clr: 1'b1};
        mac_a      = GAIN_W'(K_LEAK);
        mac_b      = (W+1)'(leaky_integral);
        state_next = ST_INTEG;
      end
      ST_INTEG:  state_next = ST_MUL_P;
      ST_MUL_P: begin
        mac_ctl    = '{en: 1'b1, clr: 1'b1};
        mac_a      = gains.gp;
        mac_b      = (W+1)'(err_clamp);
        state_next = ST_MUL_I;
      end
      ST_MUL_I: begin
        mac_ctl    = '{en: 1'b1, clr: 1'b0};
        mac_a      = gains.gi;
        mac_b      = (W+1)'(leaky_integral);
        state_next = ST_MUL_D;
      end
      ST_MUL_D: begin
        mac_ctl    = '{en: 1'b1, clr: 1'b0};
        mac_a      = gains.gd;
        mac_b      = {error_trend, 1'b0};
        state_next = ST_SLEW;
      end
      ST_SLEW:   state_next = ST_CLAMP;
      ST_CLAMP:  state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_p_gain   <= '0;
      base_i_gain   <= '0;
      base_d_gain   <= '0;
      accel_floor   <= -13'sd1152;
      accel_ceiling <= 12'd512;
    end else if (cfg_we) begin
      priority case (cfg_index)
        CFG_BASE_P:  base_p_gain   <= cfg_data;
        CFG_BASE_I:  base_i_gain   <= cfg_data;
        CFG_BASE_D:  base_d_gain   <= cfg_data;
        CFG_FLOOR:   accel_floor   <= cfg_data[12:0];
        CFG_CEILING: accel_ceiling <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Loop state updates, one step of the sample per state.
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed_error <= '0;
      error_trend    <= '0;
      leaky_integral <= '0;
      previous_accel <= '0;
      for (int i = 0; i < 4; i++) error_history[i] <= '0;
    end else begin
      priority case (state)
        ST_SMOOTH: begin
          smoothed_error   <= sat_w(acc_round);
          error_history[0] <= error_history[1];
          error_history[1] <= error_history[2];
          error_history[2] <= error_history[3];
          error_history[3] <= sat_w(acc_round);
        end
        ST_TREND: begin
          error_trend <= sat_w(AW'(error_history[3]) + AW'(error_history[2])
                               - AW'(error_history[1]) - AW'(error_history[0]));
        end
        ST_INTEG: leaky_integral <= sat_w(acc_round + AW'(i_step));
        ST_CLAMP: begin
          if (accel_tmp > accel_hi) previous_accel <= sat_w(accel_hi);
          else if (accel_tmp < accel_lo) previous_accel <= sat_w(accel_lo);
          else previous_accel <= sat_w(accel_tmp);
        end
        default: ;
      endcase
    end
  end

  // Working registers that need no reset.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      desired  <= s_tdata[15:0];
      measured <= s_tdata[31:16];
    end
    if (state == ST_PREP) begin
      e_reg <= sat_w(AW'(speed_diff) <<< 8);
      t_reg <= sat_w(AW'(smoothed_error) + AW'(error_trend >>> 2));
    end
    if (state == ST_INTEG) gains <= gains_lut;
    if (state == ST_SLEW) begin
      if (slew_diff > AW'(RISE_LIM)) accel_tmp <= prev_ext + AW'(RISE_LIM);
      else if (slew_diff < AW'(-FALL_LIM)) accel_tmp <= prev_ext - AW'(FALL_LIM);
      else accel_tmp <= acc_round;
    end
    if (state == ST_DONE && out_free) accel_command <= out_round[12:0];
  end

  // Output register: loaded when the result is done and the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

`ifndef SYNTH
  // A result appears only as the sequencer leaves its final state.
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_DONE)
    else $error("result valid without a finished sample");

  // An input transfer always starts the sequence.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> state == ST_PREP)
    else $error("input transfer did not start the sequence");

  // The shared unit is never active while the block waits for input or for a free output.
  a_mac_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_DONE) |-> !mac_ctl.en)
    else $error("shared unit active outside a multiply step");
`endif

endmodule
